[design/bts_pkg.sv]
// bts_pkg: shared types, codes and constants of the breadcrumb trail stack
// no dependencies; imported by every other design file but bts_ram
`default_nettype none

package bts_pkg;

	localparam int TRAIL_DEPTH     = 64;
	localparam int SPACING_BITS    = 16;
	localparam int SPACING_SQ_BITS = 2 * SPACING_BITS;
	localparam logic [SPACING_BITS-1:0] SPACING_RESET = 16'd2560;
	localparam int STATUS_BITS     = 2;
	localparam int COMMAND_BITS    = 2;
	localparam int COUNT_BITS      = $clog2(TRAIL_DEPTH + 1);
	localparam int QUEUE_DEPTH     = 2;

	// request selector on the slave side
	typedef enum logic {
		OP_TELEOP = 1'b0,
		OP_RETURN = 1'b1
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		GS_INACTIVE  = 2'd0,
		GS_ACTIVE    = 2'd1,
		GS_SUCCEEDED = 2'd2,
		GS_ABORTED   = 2'd3
	} nav_status_t;

	typedef enum logic [COMMAND_BITS-1:0] {
		CMD_NONE     = 2'd0,
		CMD_INACTIVE = 2'd1,
		CMD_ACTIVE   = 2'd2
	} command_t;

	// what the back end has to do with a request
	typedef enum logic [1:0] {
		KIND_TELEOP = 2'd0,
		KIND_GOAL   = 2'd1,
		KIND_POP    = 2'd2,
		KIND_HOLD   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic [SPACING_SQ_BITS-1:0] spacing_sq;
	} item_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_GOAL = 3'd1,
		ST_SQ1  = 3'd2,
		ST_CMP1 = 3'd3,
		ST_CMP2 = 3'd4,
		ST_EMIT = 3'd5
	} back_state_t;

	// round a bit count up to whole bytes
	function automatic int pad_bytes(input int n);
		return ((n + 7) >> 3) << 3;
	endfunction

endpackage

`default_nettype wire

[design/bts_ram.sv]
// bts_ram: generic single write, single read memory with registered read
// no dependencies
`default_nettype none

module bts_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[design/bts_front.sv]
// bts_front: spacing register, request classification and spacing squaring
// depends on bts_pkg
`default_nettype none

module bts_front
	import bts_pkg::*;
#(
	parameter int COORD_BITS = 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [SPACING_BITS-1:0] cfg_data,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic                    s_tuser,
	input  wire logic [pad_bytes(3*COORD_BITS+STATUS_BITS)-1:0] s_tdata,
	input  wire logic                    q_full,
	output logic                         q_push,
	output item_ctl_t                    q_ctl,
	output logic      [3*COORD_BITS-1:0] q_pos
);

	logic [SPACING_BITS-1:0] spacing_q;
	op_t                     op;
	nav_status_t             status;
	kind_t                   kind;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RESET;
		end else if (cfg_valid) begin
			spacing_q <= cfg_data;
		end
	end

	assign op     = op_t'(s_tuser);
	assign status = nav_status_t'(s_tdata[3*COORD_BITS +: STATUS_BITS]);

	always_comb begin
		kind = KIND_TELEOP;
		if (op == OP_RETURN) begin
			unique case (status)
				GS_INACTIVE:               kind = KIND_GOAL;
				GS_ACTIVE:                 kind = KIND_HOLD;
				GS_SUCCEEDED, GS_ABORTED:  kind = KIND_POP;
				default:                   kind = KIND_HOLD;
			endcase
		end
	end

	assign q_ctl.kind       = kind;
	assign q_ctl.spacing_sq = SPACING_SQ_BITS'(spacing_q) * SPACING_SQ_BITS'(spacing_q);
	assign q_pos            = s_tdata[3*COORD_BITS-1:0];
	assign s_tready         = !q_full;
	assign q_push           = s_tvalid && !q_full;

endmodule

`default_nettype wire

[design/bts_queue.sv]
// bts_queue: short request queue between front and back end
// depends on bts_pkg for its depth
`default_nettype none

module bts_queue
	import bts_pkg::*;
#(
	parameter int WIDTH = 106
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic      [WIDTH-1:0] rdata
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

[design/bts_back.sv]
// bts_back: trail store, squared distance checks, stack update and result register
// depends on bts_pkg and bts_ram
`default_nettype none

module bts_back
	import bts_pkg::*;
#(
	parameter int COORD_BITS  = 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    q_valid,
	output logic                         q_pop,
	input  wire item_ctl_t               q_ctl,
	input  wire logic [3*COORD_BITS-1:0] q_pos,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [COMMAND_BITS-1:0]      m_tuser,
	output logic [pad_bytes(3*COORD_BITS+COUNT_BITS+1)-1:0] m_tdata
);

	localparam int AW    = $clog2(TRAIL_DEPTH);
	localparam int DW    = $clog2(TRAIL_DEPTH + 1);
	localparam int EW    = 3 * COORD_BITS;
	localparam int SQW   = 2 * COORD_BITS;
	localparam int CMPW  = (SQW + 2 > SPACING_SQ_BITS) ? SQW + 2 : SPACING_SQ_BITS;
	localparam int OUT_W = pad_bytes(3*COORD_BITS+COUNT_BITS+1);

	back_state_t                state_q, state_d;
	logic [DW-1:0]              depth_q, depth_d;
	logic [EW-1:0]              pos_q;
	logic [SPACING_SQ_BITS-1:0] s_q;
	logic [SQW-1:0]             sq_q [3];
	logic                       far1_q, near1_q;
	command_t                   res_cmd_q, res_cmd_d;
	logic                       res_ovf_q, res_ovf_d;
	logic [EW-1:0]              res_goal_q;
	logic                       m_tvalid_q;
	logic [COMMAND_BITS-1:0]    m_tuser_q;
	logic [OUT_W-1:0]           m_tdata_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, rd_data;
	logic          load_item, goal_clr, goal_load, out_load;

	logic [DW-1:0] top_w, below_w;
	logic [AW-1:0] top_addr, below_addr, push_addr;
	logic          empty, single, full;
	logic [CMPW-1:0] d_sum, s_ext;
	logic          far, near;

	bts_ram #(
		.WIDTH(EW),
		.DEPTH(TRAIL_DEPTH)
	) u_trail (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// squared axis distances between the held position and the word just read
	for (genvar k = 0; k < 3; k++) begin : g_axis
		logic signed [COORD_BITS:0] diff;
		logic        [COORD_BITS:0] mag;
		logic        [SQW-1:0]      sq;

		assign diff = $signed({pos_q[k*COORD_BITS+COORD_BITS-1], pos_q[k*COORD_BITS +: COORD_BITS]})
			- $signed({rd_data[k*COORD_BITS+COORD_BITS-1], rd_data[k*COORD_BITS +: COORD_BITS]});
		assign mag  = diff[COORD_BITS] ? $unsigned(-diff) : $unsigned(diff);
		assign sq   = SQW'(mag[COORD_BITS-1:0]) * SQW'(mag[COORD_BITS-1:0]);

		always_ff @(posedge clk) begin
			sq_q[k] <= sq;
		end
	end

	assign top_w      = depth_q - DW'(1);
	assign below_w    = depth_q - DW'(2);
	assign top_addr   = top_w[AW-1:0];
	assign below_addr = below_w[AW-1:0];
	assign push_addr  = depth_q[AW-1:0];
	assign empty      = (depth_q == '0);
	assign single     = (depth_q == DW'(1));
	assign full       = (depth_q == DW'(TRAIL_DEPTH));

	assign d_sum = CMPW'(sq_q[0]) + CMPW'(sq_q[1]) + CMPW'(sq_q[2]);
	assign s_ext = CMPW'(s_q);
	assign far   = (d_sum >= s_ext);
	assign near  = (d_sum <= s_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= '0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		depth_d   = depth_q;
		res_cmd_d = res_cmd_q;
		res_ovf_d = res_ovf_q;
		q_pop     = 1'b0;
		load_item = 1'b0;
		goal_clr  = 1'b0;
		goal_load = 1'b0;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = push_addr;
		ram_wdata = pos_q;
		ram_re    = 1'b0;
		ram_raddr = top_addr;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop     = 1'b1;
					load_item = 1'b1;
					goal_clr  = 1'b1;
					res_ovf_d = 1'b0;
					state_d   = ST_EMIT;
					unique case (q_ctl.kind)
						KIND_TELEOP: begin
							res_cmd_d = CMD_INACTIVE;
							if (empty) begin
								// first waypoint goes straight in
								ram_we    = 1'b1;
								ram_wdata = q_pos;
								depth_d   = depth_q + DW'(1);
							end else begin
								ram_re  = 1'b1;
								state_d = ST_SQ1;
							end
						end
						KIND_GOAL: begin
							if (empty) begin
								res_cmd_d = CMD_NONE;
							end else begin
								res_cmd_d = CMD_ACTIVE;
								ram_re    = 1'b1;
								state_d   = ST_GOAL;
							end
						end
						KIND_POP: begin
							if (empty) begin
								res_cmd_d = CMD_NONE;
							end else begin
								res_cmd_d = CMD_INACTIVE;
								depth_d   = depth_q - DW'(1);
							end
						end
						KIND_HOLD: res_cmd_d = CMD_NONE;
						default:   res_cmd_d = CMD_NONE;
					endcase
				end
			end
			ST_GOAL: begin
				goal_load = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_SQ1: begin
				// top word is in, fetch the one below (if there is one) while squaring
				if (!single) begin
					ram_re    = 1'b1;
					ram_raddr = below_addr;
				end
				state_d = ST_CMP1;
			end
			ST_CMP1: begin
				if (single) begin
					if (far) begin
						if (full) begin
							res_ovf_d = 1'b1;
						end else begin
							ram_we  = 1'b1;
							depth_d = depth_q + DW'(1);
						end
					end
					state_d = ST_EMIT;
				end else begin
					state_d = ST_CMP2;
				end
			end
			ST_CMP2: begin
				priority if (far1_q && far) begin
					if (full) begin
						res_ovf_d = 1'b1;
					end else begin
						ram_we  = 1'b1;
						depth_d = depth_q + DW'(1);
					end
				end else if (far1_q && near) begin
					ram_we    = 1'b1;
					ram_waddr = top_addr;
				end else if (near1_q && near) begin
					depth_d = depth_q - DW'(1);
				end else begin
					depth_d = depth_q;
				end
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		res_cmd_q <= res_cmd_d;
		res_ovf_q <= res_ovf_d;
		if (load_item) begin
			pos_q <= q_pos;
			s_q   <= q_ctl.spacing_sq;
		end
		if (state_q == ST_CMP1) begin
			far1_q  <= far;
			near1_q <= near;
		end
		if (goal_clr) begin
			res_goal_q <= '0;
		end else if (goal_load) begin
			res_goal_q <= rd_data;
		end
		if (out_load) begin
			m_tuser_q <= res_cmd_q;
			m_tdata_q <= OUT_W'({res_ovf_q, COUNT_BITS'(depth_q), res_goal_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(TRAIL_DEPTH))
		else $error("trail depth beyond capacity");

	a_depth_step: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q == $past(depth_q) || depth_q == $past(depth_q) + DW'(1)
		|| depth_q == $past(depth_q) - DW'(1))
		else $error("trail depth moved by more than one");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("trail store written and read in the same cycle");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res_ovf_q |-> full)
		else $error("overflow flagged with room left");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !m_tvalid_q |=> state_q == ST_IDLE && m_tvalid_q)
		else $error("result not loaded into a free output register");
`endif

endmodule

`default_nettype wire

[design/breadcrumb_trail_stack.sv]
// breadcrumb_trail_stack: top level joining front end, request queue and back end
// depends on bts_pkg, bts_front, bts_queue, bts_back (and bts_ram below it)
//
// usage
// - cfg channel (cfg_valid, cfg_ready, cfg_data): writes the waypoint spacing in 1/256 m,
//   always ready; write it only while no request is outstanding
// - slave stream: s_tuser selects a teleop tick or an autonomous return tick,
//   s_tdata carries the position and the goal controller status
// - master stream: exactly one result per request, m_tuser is the goal command,
//   m_tdata the goal position, the trail count after the step and the overflow flag
// - from the accepting edge a request passes the queue, then back end states IDLE and
//   EMIT if it needs no read of the waypoint store, with GOAL between for an active goal,
//   SQ1 and CMP1 for a teleop tick against one waypoint, plus CMP2 against two or more
// - the back end finishes a request before it takes the next; the single read port of the
//   waypoint store (top entry, then below) and the squared distance compare set its steps
// - a two entry queue between the ends keeps requests flowing while a result waits
// - a stalled receiver holds the result register; the back end then waits and the
//   queue fills, after which s_tready drops
// - reset empties the trail and the queue and loads the spacing with ten metres;
//   the store contents are left as they are, entries above the count are never read
`default_nettype none

module breadcrumb_trail_stack
	import bts_pkg::*;
#(
	parameter int COORD_BITS  = 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration write channel
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [SPACING_BITS-1:0] cfg_data,   // min_spacing
	// request stream
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic                    s_tuser,    // op
	// pos_x, pos_y, pos_z, status, zero fill
	input  wire logic [pad_bytes(3*COORD_BITS+STATUS_BITS)-1:0] s_tdata,
	// result stream
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [COMMAND_BITS-1:0]      m_tuser,    // command
	// goal_x, goal_y, goal_z, trail_count, trail_overflow, zero fill
	output logic [pad_bytes(3*COORD_BITS+COUNT_BITS+1)-1:0] m_tdata
);

	localparam int POS_W = 3 * COORD_BITS;
	localparam int CTL_W = $bits(item_ctl_t);
	localparam int QW    = CTL_W + POS_W;

	item_ctl_t        front_ctl, back_ctl;
	logic [POS_W-1:0] front_pos, back_pos;
	logic             q_push, q_pop, q_full, q_valid;
	logic [QW-1:0]    q_rdata;

	// classify the request and square the spacing on the way in
	bts_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_ctl    (front_ctl),
		.q_pos    (front_pos)
	);

	// decouples acceptance from the multi cycle trail update
	bts_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    ({front_ctl, front_pos}),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.rdata    (q_rdata)
	);

	assign back_ctl = item_ctl_t'(q_rdata[QW-1 -: CTL_W]);
	assign back_pos = q_rdata[POS_W-1:0];

	// trail store, distance checks and the result register
	bts_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_ctl   (back_ctl),
		.q_pos   (back_pos),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser (m_tuser),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire
